// ===== rtl/dgpc_pkg.sv =====
// Package for the debounced GPIO port controller: transfer structs, op codes,
// pin mode codes, state entry layout and default sizes. No dependencies.
package dgpc_pkg;

  localparam int NUM_PORTS_DEF  = 4;
  localparam int PORT_WIDTH_DEF = 16;

  localparam int PIN_W    = 6;
  localparam int BIT_W    = 4;   // low pin bits select the bit
  localparam int SAMPLE_W = 16;
  localparam int OP_W     = 4;

  // op codes
  localparam logic [OP_W-1:0] OP_SAMPLE   = 4'd0;
  localparam logic [OP_W-1:0] OP_REGISTER = 4'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 4'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 4'd3;
  localparam logic [OP_W-1:0] OP_TAKE     = 4'd4;
  localparam logic [OP_W-1:0] OP_CHECK    = 4'd5;
  localparam logic [OP_W-1:0] OP_WRITE    = 4'd6;
  localparam logic [OP_W-1:0] OP_READ     = 4'd7;
  localparam logic [OP_W-1:0] OP_POLL     = 4'd8;

  // pin mode codes
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_PUSH_PULL = 3'd1;
  localparam logic [2:0] MODE_PULL_DOWN = 3'd2;
  localparam logic [2:0] MODE_PULL_UP   = 3'd3;
  localparam logic [2:0] MODE_FLOAT     = 3'd4;

  // field slots inside one state entry, each PORT_WIDTH bits
  localparam int F_OOWN   = 0;
  localparam int F_IOWN   = 1;
  localparam int F_LAST   = 2;
  localparam int F_MARKS  = 3;
  localparam int F_LEVELS = 4;
  localparam int F_NUM    = 5;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PIN_W-1:0]    pin;
    logic                as_output;
    logic                npn;
    logic                value;
    logic [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic                status;
    logic                read_value;
    logic                changed;
    logic [2:0]          pin_mode;
    logic [1:0]          drive_port;
    logic [SAMPLE_W-1:0] set_mask;
    logic [SAMPLE_W-1:0] clear_mask;
  } rsp_t;

endpackage

// ===== rtl/dgpc_state_ram.sv =====
// Port state memory: one entry per port, one write and one registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
module dgpc_state_ram #(
  parameter int DEPTH  = dgpc_pkg::NUM_PORTS_DEF,
  parameter int WIDTH  = dgpc_pkg::F_NUM * dgpc_pkg::PORT_WIDTH_DEF,
  parameter int ADDR_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/dgpc_op_unit.sv =====
// Op logic: takes one request and its port entry, returns the updated entry,
// its write enable and the result. Uses dgpc_pkg.
module dgpc_op_unit #(
  parameter int NUM_PORTS  = dgpc_pkg::NUM_PORTS_DEF,
  parameter int PORT_WIDTH = dgpc_pkg::PORT_WIDTH_DEF
) (
  input  dgpc_pkg::req_t                              req_i,
  input  logic [dgpc_pkg::F_NUM*PORT_WIDTH-1:0]       entry_i,
  output logic [dgpc_pkg::F_NUM*PORT_WIDTH-1:0]       entry_o,
  output logic                                        we_o,
  output dgpc_pkg::rsp_t                              rsp_o
);

  localparam int W = PORT_WIDTH;

  logic [1:0]   port;
  logic [3:0]   bitn;
  logic         bad;
  logic [W-1:0] m, raw;
  logic [W-1:0] oown, iown, last, marks, lvl;
  logic [W-1:0] oown_n, iown_n, last_n, marks_n, lvl_n;
  logic [W-1:0] imask, omask, s, diff, flip;
  logic [31:0]  raw32, set32, clr32;

  always_comb begin
    port  = req_i.pin[dgpc_pkg::PIN_W-1:dgpc_pkg::BIT_W];
    bitn  = req_i.pin[dgpc_pkg::BIT_W-1:0];
    bad   = (req_i.op > dgpc_pkg::OP_POLL) || (32'(port) >= 32'(NUM_PORTS))
            || (32'(bitn) >= 32'(PORT_WIDTH));
    m     = W'(1) << bitn;
    raw32 = 32'(req_i.sample);
    raw   = raw32[W-1:0];

    oown  = entry_i[dgpc_pkg::F_OOWN*W   +: W];
    iown  = entry_i[dgpc_pkg::F_IOWN*W   +: W];
    last  = entry_i[dgpc_pkg::F_LAST*W   +: W];
    marks = entry_i[dgpc_pkg::F_MARKS*W  +: W];
    lvl   = entry_i[dgpc_pkg::F_LEVELS*W +: W];

    // two-sample agreement debounce over input-only pins
    imask = iown & ~oown;
    omask = oown & ~iown;
    s     = raw & imask;
    diff  = (last ^ s) & imask;
    flip  = (lvl ^ s) & imask & ~diff;

    oown_n  = oown;
    iown_n  = iown;
    last_n  = last;
    marks_n = marks;
    lvl_n   = lvl;
    set32   = '0;
    clr32   = '0;
    rsp_o   = '0;

    if (bad) begin
      rsp_o.status = 1'b1;
    end else begin
      case (req_i.op)
        dgpc_pkg::OP_SAMPLE: begin
          last_n  = (last & ~diff) | (s & diff);
          lvl_n   = lvl ^ flip;
          marks_n = marks | flip;
          rsp_o.drive_port = port;
          set32 = 32'(lvl_n & omask);
          clr32 = 32'(~lvl_n & omask);
        end
        dgpc_pkg::OP_REGISTER: begin
          if (((iown | oown) & m) != '0) begin
            rsp_o.status = 1'b1;
          end else begin
            marks_n = marks & ~m;
            rsp_o.drive_port = port;
            if (req_i.as_output) begin
              oown_n = oown | m;
              rsp_o.pin_mode = dgpc_pkg::MODE_PUSH_PULL;
              if (req_i.npn) begin
                lvl_n = lvl | m;
                set32 = 32'(m);
              end else begin
                lvl_n = lvl & ~m;
                clr32 = 32'(m);
              end
            end else begin
              iown_n = iown | m;
              if (req_i.npn) begin
                rsp_o.pin_mode = dgpc_pkg::MODE_PULL_UP;
                last_n = last | m;
                lvl_n  = lvl | m;
              end else begin
                rsp_o.pin_mode = dgpc_pkg::MODE_PULL_DOWN;
                last_n = last & ~m;
                lvl_n  = lvl & ~m;
              end
            end
          end
        end
        dgpc_pkg::OP_DELETE: begin
          oown_n = oown & ~m;
          iown_n = iown & ~m;
          rsp_o.pin_mode = dgpc_pkg::MODE_FLOAT;
        end
        dgpc_pkg::OP_RELEASE: begin
          oown_n = oown & ~m;
          iown_n = iown & ~m;
        end
        dgpc_pkg::OP_TAKE: begin
          oown_n = oown | m;
          iown_n = iown | m;
        end
        dgpc_pkg::OP_CHECK: begin
          rsp_o.status = ((iown | oown) & m) != '0;
        end
        dgpc_pkg::OP_WRITE: begin
          marks_n = marks & ~m;
          lvl_n   = (req_i.value ^ req_i.npn) ? (lvl | m) : (lvl & ~m);
        end
        dgpc_pkg::OP_READ: begin
          marks_n = marks & ~m;
          rsp_o.read_value = ((lvl & m) != '0) ^ req_i.npn;
        end
        default: begin
          rsp_o.changed = (marks & m) != '0;
        end
      endcase
    end

    rsp_o.set_mask   = set32[dgpc_pkg::SAMPLE_W-1:0];
    rsp_o.clear_mask = clr32[dgpc_pkg::SAMPLE_W-1:0];
    we_o = !bad;

    entry_o = '0;
    entry_o[dgpc_pkg::F_OOWN*W   +: W] = oown_n;
    entry_o[dgpc_pkg::F_IOWN*W   +: W] = iown_n;
    entry_o[dgpc_pkg::F_LAST*W   +: W] = last_n;
    entry_o[dgpc_pkg::F_MARKS*W  +: W] = marks_n;
    entry_o[dgpc_pkg::F_LEVELS*W +: W] = lvl_n;
  end

endmodule

// ===== rtl/debounced_gpio_port_controller_unit.sv =====
// Debounced GPIO port controller, top level.
// Depends on dgpc_pkg, dgpc_state_ram and dgpc_op_unit.
//
// Usage:
//   Command channel: drive req_i and raise start; the transfer happens at a
//   rising edge with start high and busy low. busy stays high for the cycle
//   in which the item is worked on.
//   Result channel: done_o pulses for exactly one cycle with rsp_o; the
//   receiver takes it at the edge closing that cycle and cannot stall it.
// Timing:
//   The port entry is read from the state memory at the accept edge into its
//   registered read port; the next cycle modifies it and writes it back, and
//   the result is registered at that edge, so done_o is high in the cycle
//   after the work cycle. busy blocks a new item until the work cycle of the
//   previous one is over. A new read always lands after the previous
//   write-back, so no forwarding is needed.
// Reset:
//   rst_ni clears the control state and the memory's per-port valid bits;
//   every port reads as all zero (all pins free) until first written.
module debounced_gpio_port_controller_unit #(
  parameter int NUM_PORTS  = dgpc_pkg::NUM_PORTS_DEF,
  parameter int PORT_WIDTH = dgpc_pkg::PORT_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dgpc_pkg::req_t req_i,
  output logic           done_o,
  output dgpc_pkg::rsp_t rsp_o
);

  localparam int ADDR_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int ENTRY_W = dgpc_pkg::F_NUM * PORT_WIDTH;

  // state codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state_q, state_d;
  logic                done_q;
  dgpc_pkg::req_t      req_q;
  dgpc_pkg::rsp_t      rsp_q, rsp_d;
  logic                accept;
  logic [31:0]         rport_ext, wport_ext;
  logic [ADDR_W-1:0]   raddr, waddr;
  logic [ENTRY_W-1:0]  rdata, wdata;
  logic                wr_en;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_EXEC);

  // port number = upper pin bits; out-of-range ports never write
  assign rport_ext = 32'(req_i.pin[dgpc_pkg::PIN_W-1:dgpc_pkg::BIT_W]);
  assign wport_ext = 32'(req_q.pin[dgpc_pkg::PIN_W-1:dgpc_pkg::BIT_W]);
  assign raddr     = rport_ext[ADDR_W-1:0];
  assign waddr     = wport_ext[ADDR_W-1:0];

  dgpc_state_ram #(
    .DEPTH  (NUM_PORTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (busy && wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  dgpc_op_unit #(
    .NUM_PORTS  (NUM_PORTS),
    .PORT_WIDTH (PORT_WIDTH)
  ) u_op (
    .req_i   (req_q),
    .entry_i (rdata),
    .entry_o (wdata),
    .we_o    (wr_en),
    .rsp_o   (rsp_d)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= busy;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (busy) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // each accepted item yields its result strobe after its work cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing after accepted item");

  // no result strobe without a previously accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without accepted item");

  // work cycle lasts exactly one cycle
  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // result never coincides with the work cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe during work cycle");

endmodule
